FILE: sv/tile_directory_lookup_top_assert.svh
// Assertion macros shared by the lookup block.
// They expect signals named clk and rst in the module that uses them.
`ifndef TILE_DIRECTORY_LOOKUP_TOP_ASSERT_SVH
`define TILE_DIRECTORY_LOOKUP_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define TDL_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("tile directory lookup: property failed");
`define TDL_ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("tile directory lookup: forbidden condition seen");
`else
`define TDL_ASSERT(lbl, prop)
`define TDL_ASSERT_NEVER(lbl, expr)
`endif

`endif

FILE: sv/tdl_pkg.sv
`timescale 1ns / 1ps
package tdl_pkg;

  localparam int MAX_ENTRIES = 1024;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  // Parse phase codes.
  localparam logic [2:0] PH_COUNT = 3'd0;
  localparam logic [2:0] PH_IDS   = 3'd1;
  localparam logic [2:0] PH_RUNS  = 3'd2;
  localparam logic [2:0] PH_LENS  = 3'd3;
  localparam logic [2:0] PH_OFFS  = 3'd4;
  localparam logic [2:0] PH_DONE  = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_NOT_FOUND = 2'd0;
  localparam logic [1:0] ST_TILE      = 2'd1;
  localparam logic [1:0] ST_LEAF      = 2'd2;
  localparam logic [1:0] ST_REJECTED  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take;
    logic start;
    logic run;
    logic rearm;
  } tdl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic done;
  } tdl_stat_t;

endpackage

FILE: sv/tile_directory_lookup_top.sv
`timescale 1ns / 1ps
// Directory lookup: takes one decompressed tile directory, one byte per cycle with
// no stall, until the byte marked last; that byte also samples wanted_id. The block
// then walks the stored entries, one memory read per cycle, and presents a single
// result (tile, leaf, not found or rejected). The result stays on the outputs until
// its transfer, after which the next directory's first byte can be taken. Up to
// 1024 entries are held.
module tile_directory_lookup_top import tdl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  dir_byte,
  input  logic        last_byte,
  input  logic [63:0] wanted_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [63:0] entry_offset,
  output logic [63:0] entry_length
);

  tdl_cmd_t  cmd;
  tdl_stat_t stat;

  tdl_control u_control (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .last_byte (last_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  tdl_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .dir_byte     (dir_byte),
    .wanted_id    (wanted_id),
    .status       (status),
    .entry_offset (entry_offset),
    .entry_length (entry_length)
  );

endmodule

FILE: sv/tdl_datapath.sv
`timescale 1ns / 1ps
module tdl_datapath import tdl_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  tdl_cmd_t    cmd,
  output tdl_stat_t   stat,
  input  logic [7:0]  dir_byte,
  input  logic [63:0] wanted_id,
  output logic [1:0]  status,
  output logic [63:0] entry_offset,
  output logic [63:0] entry_length
);

  logic [63:0] id_store     [MAX_ENTRIES];
  logic [63:0] run_store    [MAX_ENTRIES];
  logic [63:0] length_store [MAX_ENTRIES];
  logic [63:0] offset_store [MAX_ENTRIES];

  logic [63:0]      varint_accum, varint_accum_next;
  logic [6:0]       varint_shift, varint_shift_next;
  logic [2:0]       parse_phase, parse_phase_next;
  logic [CNT_W-1:0] entry_count, entry_count_next;
  logic [CNT_W-1:0] entry_index, entry_index_next;
  logic [63:0]      running_id, running_id_next;
  logic             malformed_flag, malformed_flag_next;
  logic [63:0]      prev_off, prev_off_next;

  logic [63:0]       acc_or;
  logic [63:0]       off_val;
  logic [CNT_W-1:0]  idx_inc;
  logic              wr_id, wr_run, wr_len, wr_off;
  logic [ADDR_W-1:0] waddr, raddr;

  logic [CNT_W-1:0] s_addr;
  logic             rd_valid, rd_last, h_valid, h_last, issue;
  logic [63:0]      rd_id, rd_run, rd_len, rd_off;
  logic [63:0]      h_id, h_run, h_len, h_off, want, diff;
  logic             eval, ge, leaf_hit, tile_hit, parse_ok;

  // Varint decode and field sequencing for one accepted byte.
  always_comb begin
    acc_or              = varint_accum | ({57'd0, dir_byte[6:0]} << varint_shift[5:0]);
    varint_accum_next   = varint_accum;
    varint_shift_next   = varint_shift;
    parse_phase_next    = parse_phase;
    entry_count_next    = entry_count;
    entry_index_next    = entry_index;
    running_id_next     = running_id;
    malformed_flag_next = malformed_flag;
    prev_off_next       = prev_off;
    idx_inc             = entry_index + CNT_W'(1);
    off_val             = acc_or - 64'd1;
    wr_id  = 1'b0;
    wr_run = 1'b0;
    wr_len = 1'b0;
    wr_off = 1'b0;
    if (acc_or == 64'd0 && entry_index != '0) begin
      off_val = prev_off + rd_len;
    end
    if (cmd.rearm) begin
      varint_accum_next   = '0;
      varint_shift_next   = '0;
      parse_phase_next    = PH_COUNT;
      entry_count_next    = '0;
      entry_index_next    = '0;
      running_id_next     = '0;
      malformed_flag_next = 1'b0;
    end else if (cmd.take && !malformed_flag && parse_phase < PH_DONE) begin
      if (varint_shift > 7'd63) begin
        malformed_flag_next = 1'b1;
      end else if (dir_byte[7]) begin
        varint_accum_next = acc_or;
        varint_shift_next = varint_shift + 7'd7;
      end else begin
        varint_accum_next = '0;
        varint_shift_next = '0;
        if (parse_phase == PH_COUNT) begin
          if (acc_or == 64'd0 || acc_or > 64'(MAX_ENTRIES)) begin
            malformed_flag_next = 1'b1;
          end else begin
            entry_count_next = acc_or[CNT_W-1:0];
            entry_index_next = '0;
            parse_phase_next = PH_IDS;
          end
        end else begin
          case (parse_phase)
            PH_IDS: begin
              running_id_next = running_id + acc_or;
              wr_id           = 1'b1;
            end
            PH_RUNS: wr_run = 1'b1;
            PH_LENS: wr_len = 1'b1;
            PH_OFFS: begin
              wr_off        = 1'b1;
              prev_off_next = off_val;
            end
            default: ;
          endcase
          entry_index_next = idx_inc;
          if (idx_inc >= entry_count) begin
            entry_index_next = '0;
            parse_phase_next = parse_phase + 3'd1;
          end
        end
      end
    end
  end

  // Parser registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      varint_accum   <= '0;
      varint_shift   <= '0;
      parse_phase    <= PH_COUNT;
      entry_count    <= '0;
      entry_index    <= '0;
      running_id     <= '0;
      malformed_flag <= 1'b0;
    end else begin
      varint_accum   <= varint_accum_next;
      varint_shift   <= varint_shift_next;
      parse_phase    <= parse_phase_next;
      entry_count    <= entry_count_next;
      entry_index    <= entry_index_next;
      running_id     <= running_id_next;
      malformed_flag <= malformed_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    prev_off <= prev_off_next;
  end

  // While parsing, the length port looks up the previous entry for offset deltas.
  assign waddr = entry_index[ADDR_W-1:0];
  assign raddr = cmd.run ? s_addr[ADDR_W-1:0] : ADDR_W'(entry_index_next - CNT_W'(1));
  assign issue = cmd.run && (s_addr < entry_count);

  // Entry stores.
  always_ff @(posedge clk) begin
    if (wr_id) begin
      id_store[waddr] <= running_id_next;
    end
    rd_id <= id_store[raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_run) begin
      run_store[waddr] <= acc_or;
    end
    rd_run <= run_store[raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_len) begin
      length_store[waddr] <= acc_or;
    end
    rd_len <= length_store[raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_off) begin
      offset_store[waddr] <= off_val;
    end
    rd_off <= offset_store[raddr];
  end

  // Search walk: one read per cycle, each entry judged once its successor is read, the last one on its own.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_addr   <= '0;
      rd_valid <= 1'b0;
      rd_last  <= 1'b0;
      h_valid  <= 1'b0;
      h_last   <= 1'b0;
    end else if (cmd.start) begin
      s_addr   <= '0;
      rd_valid <= 1'b0;
      h_valid  <= 1'b0;
    end else if (cmd.run) begin
      rd_valid <= issue;
      rd_last  <= (s_addr == entry_count - CNT_W'(1));
      if (issue) begin
        s_addr <= s_addr + CNT_W'(1);
      end
      if (rd_valid) begin
        h_valid <= 1'b1;
        h_last  <= rd_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      want <= wanted_id;
    end
    if (rd_valid) begin
      h_id  <= rd_id;
      h_run <= rd_run;
      h_len <= rd_len;
      h_off <= rd_off;
    end
  end

  // Match test for the held entry.
  assign parse_ok  = !malformed_flag && (parse_phase == PH_DONE);
  assign eval      = h_valid && (rd_valid || h_last);
  assign ge        = (want >= h_id);
  assign diff      = want - h_id;
  assign leaf_hit  = eval && ge && (h_run == 64'd0) && (h_last || want < rd_id);
  assign tile_hit  = eval && ge && (h_run != 64'd0) && (diff < h_run);
  assign stat.done = cmd.run && (!parse_ok || leaf_hit || tile_hit || (eval && h_last));

  // Result registers.
  always_ff @(posedge clk) begin
    if (stat.done) begin
      if (!parse_ok) begin
        status       <= ST_REJECTED;
        entry_offset <= '0;
        entry_length <= '0;
      end else if (leaf_hit || tile_hit) begin
        status       <= leaf_hit ? ST_LEAF : ST_TILE;
        entry_offset <= h_off;
        entry_length <= h_len;
      end else begin
        status       <= ST_NOT_FOUND;
        entry_offset <= '0;
        entry_length <= '0;
      end
    end
  end

endmodule

FILE: sv/tdl_control.sv
`timescale 1ns / 1ps
`include "tile_directory_lookup_top_assert.svh"
module tdl_control import tdl_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      last_byte,
  output logic      out_valid,
  input  logic      out_stall,
  output tdl_cmd_t  cmd,
  input  tdl_stat_t stat
);

  typedef enum logic [2:0] {
    S_PARSE  = 3'b001,
    S_SEARCH = 3'b010,
    S_RESULT = 3'b100
  } state_t;

  state_t state, state_next;

  // Sequencing: parse bytes, walk entries, hold the result.
  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      S_PARSE: begin
        in_stall  = 1'b0;
        cmd.take  = in_valid;
        cmd.start = in_valid && last_byte;
        if (in_valid && last_byte) begin
          state_next = S_SEARCH;
        end
      end
      S_SEARCH: begin
        cmd.run = 1'b1;
        if (stat.done) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          cmd.rearm  = 1'b1;
          state_next = S_PARSE;
        end
      end
      default: state_next = S_PARSE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_PARSE;
    end else begin
      state <= state_next;
    end
  end

  `TDL_ASSERT(a_start_to_search, cmd.start |=> state == S_SEARCH)
  `TDL_ASSERT(a_done_to_result, (state == S_SEARCH && stat.done) |=> out_valid)
  `TDL_ASSERT_NEVER(a_no_take_when_busy, cmd.take && (cmd.run || out_valid))
  `TDL_ASSERT(a_rearm_on_transfer, cmd.rearm |=> !in_stall)

endmodule
